@@ hdl/scf_pkg.sv @@
package scf_pkg;

  localparam int Q_DEPTH = 8;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  localparam logic [12:0] WIDTH_RESET = 13'd640;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pix_t;

  typedef struct packed {
    logic [15:0] out_row;
    logic [11:0] out_col;
    logic [7:0]  value;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic        valid;
    logic        rge1;
    logic        rge2;
    logic        interior;
    logic        emit;
    logic        lastcol;
    logic [15:0] row;
    logic [11:0] col;
    logic [11:0] bcol;
    logic [7:0]  pix;
  } scf_ctl_t;

  typedef struct packed {
    logic [15:0] row;
    logic [11:0] col;
    logic [7:0]  value;
    logic        lastcol;
    logic [11:0] bcol;
  } scf_entry_t;

endpackage

@@ hdl/scf_line_mem.sv @@
module scf_line_mem import scf_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          acc,
  input  logic [CW-1:0] addr,
  input  logic [7:0]    pix,
  input  logic          rge1,
  output logic [7:0]    mid_q,
  output logic [7:0]    abv_q
);

  logic [7:0]    line_middle [MAX_WIDTH];
  logic [7:0]    line_above  [MAX_WIDTH];
  logic [CW-1:0] wr_addr;
  logic          wr_en;

  always_ff @(posedge clk) begin
    if (acc) begin
      mid_q <= line_middle[addr];
      abv_q <= line_above[addr];
      line_middle[addr] <= pix;
      wr_addr <= addr;
    end
    if (wr_en) begin
      line_above[wr_addr] <= mid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_en <= 1'b0;
    end else begin
      wr_en <= acc & rge1;
    end
  end

endmodule

@@ hdl/scf_window.sv @@
module scf_window import scf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  scf_ctl_t   ctl,
  input  logic [7:0] mid_q,
  input  logic [7:0] abv_q,
  output logic       push,
  output scf_entry_t entry
);

  logic [7:0]  mid_l;
  logic [7:0]  mid_c;
  logic [7:0]  top_c;
  logic [7:0]  prev_pix;
  logic [7:0]  m_new;
  logic [7:0]  a_new;
  logic [11:0] five;
  logic [11:0] neg;
  logic [11:0] s;
  logic [7:0]  val;

  assign m_new = ctl.rge1 ? mid_q : 8'd0;
  assign a_new = ctl.rge2 ? abv_q : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_l    <= 8'd0;
      mid_c    <= 8'd0;
      top_c    <= 8'd0;
      prev_pix <= 8'd0;
    end else if (ctl.valid) begin
      mid_l    <= mid_c;
      mid_c    <= m_new;
      top_c    <= a_new;
      prev_pix <= ctl.pix;
    end
  end

  always_comb begin
    five = {2'b00, mid_c, 2'b00} + {4'b0000, mid_c};
    neg  = {4'b0000, mid_l} + {4'b0000, m_new} + {4'b0000, top_c} + {4'b0000, prev_pix};
    s    = five - neg;
    if (!ctl.interior || s[11]) begin
      val = 8'd0;
    end else if (s[10:8] != 3'd0) begin
      val = 8'hFF;
    end else begin
      val = s[7:0];
    end
  end

  assign push          = ctl.valid & ctl.emit;
  assign entry.row     = ctl.row;
  assign entry.col     = ctl.col;
  assign entry.value   = val;
  assign entry.lastcol = ctl.lastcol;
  assign entry.bcol    = ctl.bcol;

endmodule

@@ hdl/scf_out_queue.sv @@
module scf_out_queue import scf_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  scf_entry_t      entry,
  input  logic            res_stall,
  output logic            res_valid,
  output res_t            res,
  output logic [Q_CW-1:0] count
);

  scf_entry_t      q [Q_DEPTH];
  scf_entry_t      head;
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic            bord_pend;
  logic [15:0]     bord_row;
  logic [11:0]     bord_col;
  logic            load;
  logic            pop;

  assign head = q[rptr];
  assign load = ~res_valid | ~res_stall;
  assign pop  = load & ~bord_pend & (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr      <= '0;
      rptr      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
      bord_pend <= 1'b0;
    end else begin
      if (push) begin
        wptr <= wptr + Q_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + Q_AW'(1);
      end
      count <= count + {{(Q_CW-1){1'b0}}, push} - {{(Q_CW-1){1'b0}}, pop};
      if (load) begin
        if (bord_pend) begin
          res_valid <= 1'b1;
          bord_pend <= 1'b0;
        end else if (pop) begin
          res_valid <= 1'b1;
          bord_pend <= head.lastcol;
        end else begin
          res_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (bord_pend) begin
        res.out_row     <= bord_row;
        res.out_col     <= bord_col;
        res.value       <= 8'd0;
        res.last_of_run <= 1'b1;
      end else if (pop) begin
        res.out_row     <= head.row;
        res.out_col     <= head.col;
        res.value       <= head.value;
        res.last_of_run <= ~head.lastcol;
        bord_row        <= head.row;
        bord_col        <= head.bcol;
      end
    end
  end

endmodule

@@ hdl/sharpen_3x3_cross_filter_top.sv @@
// Throughput: one pixel item per cycle while pix_stall is low; each row of W pixels after the first
// row of a frame gives W result items. A result item passes the line store read and control registers,
// then a result queue entry, then the res output register; res_stall holds items in the queue.
// Input stalls only when the eight-entry result queue could overflow.
// Reset (rst, synchronous): clears counters, window and queue; image_width to 640.
// Line stores are not cleared by reset.
module sharpen_3x3_cross_filter_top import scf_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pix_valid,
  output logic        pix_stall,
  input  pix_t        pix,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_width
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > 13) ? $clog2(MAX_WIDTH + 1) : 13;
  localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);
  localparam logic [WW-1:0] W_LO  = WW'(3);

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (&v) ? v : v + 16'd1;
  endfunction

  function automatic logic [11:0] col12(input logic [CW-1:0] v);
    logic [CW+11:0] t;
    t = (CW + 12)'(v);
    return t[11:0];
  endfunction

  logic [12:0]     image_width;
  logic [WW-1:0]   wz;
  logic [WW-1:0]   weff;
  logic [CW-1:0]   wm1;
  logic [CW-1:0]   col_cnt;
  logic [15:0]     row_cnt;
  logic [CW-1:0]   c_cur;
  logic [15:0]     r_cur;
  logic            lastcol;
  logic [CW-1:0]   col_next;
  logic [15:0]     row_next;
  logic            acc;
  scf_ctl_t        ctl;
  scf_ctl_t        ctl_next;
  logic [7:0]      mid_q;
  logic [7:0]      abv_q;
  logic            push;
  scf_entry_t      entry;
  logic [Q_CW-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
    end else if (cfg_valid) begin
      image_width <= cfg_width;
    end
  end

  always_comb begin
    wz = WW'(image_width);
    if (wz < W_LO) begin
      weff = W_LO;
    end else if (wz > W_MAX) begin
      weff = W_MAX;
    end else begin
      weff = wz;
    end
  end

  assign wm1 = CW'(weff - WW'(1));
  assign acc = pix_valid & ~pix_stall;

  always_comb begin
    c_cur = col_cnt;
    r_cur = row_cnt;
    if (pix.frame_start) begin
      c_cur = '0;
      r_cur = '0;
    end else if (col_cnt > wm1) begin
      c_cur = '0;
      r_cur = sat_inc(row_cnt);
    end
    lastcol  = (c_cur == wm1);
    col_next = lastcol ? '0 : c_cur + CW'(1);
    row_next = lastcol ? sat_inc(r_cur) : r_cur;
  end

  always_comb begin
    ctl_next.valid    = acc;
    ctl_next.rge1     = (r_cur != 16'd0);
    ctl_next.rge2     = (r_cur > 16'd1);
    ctl_next.interior = (r_cur > 16'd1) && (c_cur > CW'(1));
    ctl_next.emit     = (r_cur != 16'd0) && (c_cur != '0);
    ctl_next.lastcol  = lastcol;
    ctl_next.row      = r_cur - 16'd1;
    ctl_next.col      = col12(c_cur - CW'(1));
    ctl_next.bcol     = col12(wm1);
    ctl_next.pix      = pix.pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      row_cnt   <= '0;
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= acc;
      if (acc) begin
        col_cnt <= col_next;
        row_cnt <= row_next;
      end
    end
    if (acc) begin
      ctl.rge1     <= ctl_next.rge1;
      ctl.rge2     <= ctl_next.rge2;
      ctl.interior <= ctl_next.interior;
      ctl.emit     <= ctl_next.emit;
      ctl.lastcol  <= ctl_next.lastcol;
      ctl.row      <= ctl_next.row;
      ctl.col      <= ctl_next.col;
      ctl.bcol     <= ctl_next.bcol;
      ctl.pix      <= ctl_next.pix;
    end
  end

  assign pix_stall = ({1'b0, q_count} + {{Q_CW{1'b0}}, ctl.valid}) >= (Q_CW + 1)'(Q_DEPTH);

  scf_line_mem #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .acc   (acc),
    .addr  (c_cur),
    .pix   (pix.pixel),
    .rge1  (ctl_next.rge1),
    .mid_q (mid_q),
    .abv_q (abv_q)
  );

  scf_window u_win (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .mid_q (mid_q),
    .abv_q (abv_q),
    .push  (push),
    .entry (entry)
  );

  scf_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry     (entry),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res       (res),
    .count     (q_count)
  );

endmodule

@@ hdl/scf_checker.sv @@
module scf_checker import scf_pkg::*; (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result item changed");

  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  a_border: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && !res.last_of_run |=>
      res_valid && res.last_of_run && res.value == 8'd0 &&
      res.out_row == $past(res.out_row))
    else $error("missing right border item");

  a_left: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.out_col == 12'd0 |-> res.value == 8'd0 && res.last_of_run)
    else $error("left border item not zero");

endmodule

bind sharpen_3x3_cross_filter_top scf_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

@@ sim/tb_sharpen_3x3_cross_filter_top.sv @@
`timescale 1ns / 1ps

import scf_pkg::*;

class sharpen_scoreboard;
  bit [7:0]    line_top [4096];
  bit [7:0]    line_mid [4096];
  int unsigned col_cnt;
  int unsigned row_cnt;
  int unsigned width_eff;
  bit [7:0]    mid_l2, mid_l1, mid_c, top_l1, top_c, prev_pix;
  res_t        pending [$];
  int          errors;

  function new();
    col_cnt = 0;
    row_cnt = 0;
    width_eff = 640;
    {mid_l2, mid_l1, mid_c, top_l1, top_c, prev_pix} = '0;
    errors = 0;
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 30) $display("%0t ns: %s", $time, msg);
  endtask

  function int unsigned clamp_width(bit [12:0] w);
    if (w < 3) return 3;
    if (w > 4096) return 4096;
    return {19'd0, w};
  endfunction

  // returns 1 when the effective width rises
  function bit set_width(bit [12:0] w);
    int unsigned nw;
    nw = clamp_width(w);
    set_width = nw > width_eff;
    width_eff = nw;
  endfunction

  function void push_result(int unsigned r, int unsigned c, int unsigned v, bit last);
    res_t e;
    e.out_row = r[15:0];
    e.out_col = c[11:0];
    e.value = v[7:0];
    e.last_of_run = last;
    pending.push_back(e);
  endfunction

  function void advance_row();
    col_cnt = 0;
    if (row_cnt < 65535) row_cnt++;
  endfunction

  function void note_pixel(pix_t p);
    int unsigned r, c, val;
    bit [7:0]    m_new, a_new;
    bit          last_col;
    int          s;
    if (p.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end else if (col_cnt >= width_eff) begin
      advance_row();
    end
    r = row_cnt;
    c = col_cnt;
    m_new = '0;
    a_new = '0;
    if (r >= 2) a_new = line_top[c[11:0]];
    if (r >= 1) begin
      m_new = line_mid[c[11:0]];
      line_top[c[11:0]] = m_new;
    end
    line_mid[c[11:0]] = p.pixel;
    mid_l2 = mid_l1;
    mid_l1 = mid_c;
    mid_c = m_new;
    top_l1 = top_c;
    top_c = a_new;
    if (r >= 1 && c >= 1) begin
      val = 0;
      last_col = (c == width_eff - 1);
      if (r >= 2 && c >= 2) begin
        s = 5 * int'(mid_l1) - int'(mid_l2) - int'(mid_c) - int'(top_l1) - int'(prev_pix);
        if (s < 0) s = 0;
        if (s > 255) s = 255;
        val = s;
      end
      push_result(r - 1, c - 1, val, !last_col);
      if (last_col) push_result(r - 1, width_eff - 1, 0, 1'b1);
    end
    prev_pix = p.pixel;
    col_cnt = c + 1;
    if (col_cnt >= width_eff) advance_row();
  endfunction

  task check_result(res_t got);
    res_t want;
    if (pending.size() == 0) begin
      report($sformatf("unexpected item row %0d col %0d value %0d",
                       got.out_row, got.out_col, got.value));
      return;
    end
    want = pending.pop_front();
    if (got.out_row != want.out_row)
      report($sformatf("out_row %0d, expected %0d", got.out_row, want.out_row));
    if (got.out_col != want.out_col)
      report($sformatf("out_col %0d, expected %0d (row %0d)",
                       got.out_col, want.out_col, want.out_row));
    if (got.value != want.value)
      report($sformatf("value %0d, expected %0d at row %0d col %0d",
                       got.value, want.value, want.out_row, want.out_col));
    if (got.last_of_run != want.last_of_run)
      report($sformatf("last_of_run %0b, expected %0b at row %0d col %0d",
                       got.last_of_run, want.last_of_run, want.out_row, want.out_col));
  endtask
endclass

module tb_sharpen_3x3_cross_filter_top;
  localparam int CycleLimit = 2000000;

  logic        clk;
  logic        rst;
  logic        pix_valid;
  logic        pix_stall;
  pix_t        pix;
  logic        res_valid;
  logic        res_stall;
  res_t        res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] cfg_width;

  sharpen_scoreboard sb;
  int unsigned       cycles = 0;
  int unsigned       burst_left = 0;
  int                stall_mode = 0;
  int                stall_run = 0;

  sharpen_3x3_cross_filter_top uut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_width (cfg_width)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(res);
  end

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run = $urandom_range(4, 60);
    end
    stall_run--;
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= 1'($urandom_range(0, 1));
      2: res_stall <= ($urandom_range(0, 3) != 0);
      default: res_stall <= (cycles % 3 == 0);
    endcase
  end

  function int unsigned next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 30);
    if ($urandom_range(0, 7) == 0) return $urandom_range(5, 20);
    return $urandom_range(1, 4);
  endfunction

  function logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task put_pixel(input logic [7:0] value, input logic fs);
    int unsigned gap;
    pix_t        item;
    gap = next_gap();
    item.pixel = value;
    item.frame_start = fs;
    repeat (gap) begin
      @(negedge clk);
      pix_valid <= 1'b0;
    end
    @(negedge clk);
    pix_valid <= 1'b1;
    pix <= item;
    do @(posedge clk); while (pix_stall);
    sb.note_pixel(item);
  endtask

  task drop_valid();
    @(negedge clk);
    pix_valid <= 1'b0;
  endtask

  task wait_idle();
    int k;
    for (k = 0; k < 20000 && sb.pending.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_width(input logic [12:0] w, output bit raised);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_width <= w;
    do @(posedge clk); while (!cfg_ready);
    raised = sb.set_width(w);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // a raised width must open a fresh frame so no unwritten line entry is read
  task run_phase(input logic [12:0] w, input int n, input int fs_rate);
    bit raised;
    bit fs;
    int i;
    write_width(w, raised);
    for (i = 0; i < n; i++) begin
      fs = (i == 0 && raised) || (fs_rate > 0 && $urandom_range(0, fs_rate - 1) == 0);
      put_pixel(rand_pixel(), fs);
    end
    drop_valid();
  endtask

  initial begin
    bit raised;
    int i;
    sb = new();
    rst = 1'b1;
    pix_valid = 1'b0;
    pix = '0;
    res_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_width = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // checkerboard frame at width 4, then a frame start mid-row
    write_width(13'd4, raised);
    for (i = 0; i < 20; i++)
      put_pixel((((i / 4) + (i % 4)) % 2) ? 8'd255 : 8'd0, i == 0);
    put_pixel(8'd1, 1'b0);
    put_pixel(8'd128, 1'b0);
    put_pixel(8'd254, 1'b1);
    put_pixel(8'd7, 1'b0);
    put_pixel(8'd255, 1'b0);
    drop_valid();

    run_phase(13'd3, 90, 80);
    run_phase(13'd0, 60, 80);
    run_phase(13'd9, 61, 0);
    run_phase(13'd5, 60, 80);
    run_phase(13'd2, 50, 80);
    run_phase(13'd1, 40, 80);
    run_phase(13'd12, 100, 80);
    run_phase(13'd7, 80, 80);
    for (i = 0; i < 4; i++)
      run_phase(13'($urandom_range(3, 16)), $urandom_range(30, 50), 60);
    run_phase(13'd8191, 40, 0);
    run_phase(13'd6, 60, 80);

    wait_idle();
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected items never arrived", sb.pending.size()));
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

@@ files.f @@
hdl/scf_pkg.sv
hdl/scf_line_mem.sv
hdl/scf_window.sv
hdl/scf_out_queue.sv
hdl/sharpen_3x3_cross_filter_top.sv
hdl/scf_checker.sv
sim/tb_sharpen_3x3_cross_filter_top.sv
